### design/tbes_pkg.sv
// Shared types, register and request codes for the tone burst envelope sequencer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tbes_pkg;

  // Widths fixed by the register map and the Q1.15 format
  localparam int LEN_BITS       = 16;
  localparam int REPEAT_BITS    = 8;
  localparam int GAIN_BITS      = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int ACTION_BITS    = 2;
  localparam int ENV_BITS       = 16;
  localparam int Q15_SHIFT      = 15;
  localparam int Q15_BIAS       = 32767;

  // Envelope value for unity gain (1.0 in Q1.15)
  localparam logic [ENV_BITS-1:0] ENV_ONE = ENV_BITS'(32768);

  // Defaults for the top-level parameters
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_COUNT_BITS  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_BURST_LENGTH    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAUSE_LENGTH    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_LENGTH     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_COUNT    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TWO_TONE_ENABLE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_GAIN     = 3'd5;

  // Register reset values
  localparam logic [LEN_BITS-1:0]    RST_BURST_LENGTH = 16'd7200;
  localparam logic [LEN_BITS-1:0]    RST_PAUSE_LENGTH = 16'd0;
  localparam logic [LEN_BITS-1:0]    RST_FADE_LENGTH  = 16'd480;
  localparam logic [REPEAT_BITS-1:0] RST_REPEAT_COUNT = 8'd1;
  localparam logic [GAIN_BITS-1:0]   RST_OUTPUT_GAIN  = 16'd22938;

  // Request action codes
  localparam logic [ACTION_BITS-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_START = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_STOP  = 2'd2;

  typedef struct packed {
    logic [LEN_BITS-1:0]    burst_length;
    logic [LEN_BITS-1:0]    pause_length;
    logic [LEN_BITS-1:0]    fade_length;
    logic [REPEAT_BITS-1:0] repeat_count;
    logic                   two_tone_enable;
    logic [GAIN_BITS-1:0]   output_gain;
  } cfg_regs_t;

  typedef struct packed {
    logic seq_active;
    logic in_burst;
    logic second_tone;
  } seq_flags_t;

  typedef struct packed {
    logic                start;
    logic [LEN_BITS-1:0] num;
    logic [LEN_BITS-1:0] den;
  } div_req_t;

endpackage

### design/tone_burst_envelope_sequencer_unit.sv
// Top level of the tone burst envelope sequencer: registers, control and output stage.
// Depends on tbes_pkg, tbes_div, tbes_mul and tbes_seq.
//
//   channel  | signals                                         | taken when
//   ---------+-------------------------------------------------+-------------------------
//   config   | cfg_write_en, cfg_index, cfg_data               | cfg_write_en high
//   request  | in_valid, in_ready, action, tone_real/imag      | in_valid & in_ready
//   result   | out_valid, out_ready, out_real/imag, tone_select,| out_valid & out_ready
//            | retune, running                                 |
//
// A tick inside a burst runs the threshold, select, gain, in-phase and quadrature steps,
// then emits; when the envelope sits on a fade, the bit-serial divider runs one bit a
// cycle between select and gain. Start, stop, idle ticks and pause ticks go straight to
// emit. One request is in work at a time; a finished result waits in the output register
// while the next request is taken. A stalled output holds the block in its last step.
// Synchronous reset clears the sequencer and restores the register defaults.
`timescale 1ns / 1ps

module tone_burst_envelope_sequencer_unit #(
  parameter int SAMPLE_BITS = tbes_pkg::DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = tbes_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [tbes_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tbes_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tbes_pkg::ACTION_BITS-1:0]    action,
  input  logic signed [SAMPLE_BITS-1:0]       tone_real,
  input  logic signed [SAMPLE_BITS-1:0]       tone_imag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_real,
  output logic signed [SAMPLE_BITS-1:0]       out_imag,
  output logic                                tone_select,
  output logic                                retune,
  output logic                                running
);
  import tbes_pkg::*;

  localparam int A_BITS   = (SAMPLE_BITS > ENV_BITS + 1) ? SAMPLE_BITS : ENV_BITS + 1;
  localparam int P_BITS   = A_BITS + GAIN_BITS + 1;
  localparam int Q_BITS   = P_BITS - Q15_SHIFT;
  localparam int CMP_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_THR   = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_GAIN  = 3'd4;
  localparam logic [2:0] S_MREAL = 3'd5;
  localparam logic [2:0] S_MIMAG = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  cfg_regs_t                      cfg;
  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [ACTION_BITS-1:0]         req_action;
  logic signed [SAMPLE_BITS-1:0]  req_real;
  logic signed [SAMPLE_BITS-1:0]  req_imag;
  logic                           shape_en;
  logic [LEN_BITS-1:0]            thr;
  logic                           early;
  logic [ENV_BITS-1:0]            env;
  logic [GAIN_BITS-1:0]           gain_sc;
  logic signed [SAMPLE_BITS-1:0]  res_real;
  logic                           accept;
  logic                           slot_free;
  logic                           emit;

  seq_flags_t                     flags;
  seq_flags_t                     flags_next;
  logic [COUNT_BITS-1:0]          count;
  logic                           seq_retune;

  div_req_t                       div_req;
  logic                           div_done;
  logic [ENV_BITS-1:0]            div_quo;

  logic                           mul_en;
  logic signed [A_BITS-1:0]       mul_a;
  logic [GAIN_BITS-1:0]           mul_b;
  logic signed [P_BITS-1:0]       prod;

  logic [CMP_BITS-1:0]            count_w;
  logic [CMP_BITS-1:0]            fade_w;
  logic [CMP_BITS-1:0]            pos_w;

  // Scale a Q1.15 product down, truncating toward zero, and clamp to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(
    input logic signed [P_BITS-1:0] p
  );
    logic signed [P_BITS-1:0]       biased;
    logic signed [Q_BITS-1:0]       q;
    logic [Q_BITS-SAMPLE_BITS:0]    high_bits;
    biased    = p[P_BITS-1] ? p + P_BITS'(Q15_BIAS) : p;
    q         = Q_BITS'(biased >>> Q15_SHIFT);
    high_bits = q[Q_BITS-1:SAMPLE_BITS-1];
    if (high_bits == '0 || high_bits == '1) begin
      return q[SAMPLE_BITS-1:0];
    end
    return {q[Q_BITS-1], {(SAMPLE_BITS-1){~q[Q_BITS-1]}}};
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign emit      = (state == S_EMIT) && slot_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{burst_length: RST_BURST_LENGTH, pause_length: RST_PAUSE_LENGTH,
               fade_length: RST_FADE_LENGTH, repeat_count: RST_REPEAT_COUNT,
               two_tone_enable: 1'b0, output_gain: RST_OUTPUT_GAIN};
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_BURST_LENGTH:    cfg.burst_length    <= cfg_data;
        REG_PAUSE_LENGTH:    cfg.pause_length    <= cfg_data;
        REG_FADE_LENGTH:     cfg.fade_length     <= cfg_data;
        REG_REPEAT_COUNT:    cfg.repeat_count    <= cfg_data[REPEAT_BITS-1:0];
        REG_TWO_TONE_ENABLE: cfg.two_tone_enable <= cfg_data[0];
        REG_OUTPUT_GAIN:     cfg.output_gain     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tbes_seq #(
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .update      (emit),
    .action      (req_action),
    .cfg         (cfg),
    .flags       (flags),
    .flags_next  (flags_next),
    .count       (count),
    .retune_next (seq_retune)
  );

  tbes_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  tbes_mul #(
    .A_BITS(A_BITS)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Envelope position compares at the common width
  always_comb begin
    count_w = CMP_BITS'(count);
    fade_w  = CMP_BITS'(cfg.fade_length);
    pos_w   = count_w - CMP_BITS'(thr);
  end

  // Sequencer state transitions
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (action == ACT_TICK && flags.seq_active && flags.in_burst) ?
                       S_THR : S_EMIT;
        end
      end
      S_THR: state_next = S_SEL;
      S_SEL: begin
        if (cfg.fade_length != '0 && (early || count_w >= CMP_BITS'(thr)) &&
            !(!early && pos_w > fade_w)) begin
          state_next = S_DIV;
        end else begin
          state_next = S_GAIN;
        end
      end
      S_DIV:   state_next = div_done ? S_GAIN : S_DIV;
      S_GAIN:  state_next = S_MREAL;
      S_MREAL: state_next = S_MIMAG;
      S_MIMAG: state_next = S_EMIT;
      S_EMIT:  state_next = slot_free ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  // Divider request: rising fade uses the count, falling fade the distance to its end
  always_comb begin
    div_req.start = (state == S_SEL) && (state_next == S_DIV);
    div_req.den   = cfg.fade_length;
    div_req.num   = early ? count_w[LEN_BITS-1:0] : cfg.fade_length - pos_w[LEN_BITS-1:0];
  end

  // Shared multiplier operands: gain scale, then in-phase, then quadrature
  always_comb begin
    mul_en = 1'b0;
    mul_a  = A_BITS'(env);
    mul_b  = cfg.output_gain;
    unique case (state)
      S_GAIN: begin
        mul_en = 1'b1;
      end
      S_MREAL: begin
        mul_en = 1'b1;
        mul_a  = A_BITS'(req_real);
        mul_b  = prod[Q15_SHIFT +: GAIN_BITS];
      end
      S_MIMAG: begin
        mul_en = 1'b1;
        mul_a  = A_BITS'(req_imag);
        mul_b  = gain_sc;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and envelope datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_real   <= tone_real;
      req_imag   <= tone_imag;
      shape_en   <= (action == ACT_TICK) && flags.seq_active && flags.in_burst;
    end
    if (state == S_THR) begin
      thr   <= (cfg.burst_length > cfg.fade_length) ?
               cfg.burst_length - cfg.fade_length : '0;
      early <= count_w < fade_w;
    end
    if (state == S_SEL) begin
      // Plateau, or past the fade end while a register changed mid-run
      env <= (!early && count_w >= CMP_BITS'(thr) && cfg.fade_length != '0) ?
             '0 : ENV_ONE;
    end
    if (state == S_DIV && div_done) begin
      env <= div_quo;
    end
    if (state == S_MREAL) begin
      gain_sc <= prod[Q15_SHIFT +: GAIN_BITS];
    end
    if (state == S_MIMAG) begin
      res_real <= scale_sat(prod);
    end
  end

  // Output register: load the finished result
  always_ff @(posedge clk) begin
    if (emit) begin
      out_real    <= shape_en ? res_real : '0;
      out_imag    <= shape_en ? scale_sat(prod) : '0;
      tone_select <= flags_next.second_tone;
      retune      <= seq_retune;
      running     <= flags_next.seq_active;
    end
  end

endmodule

### design/tbes_div.sv
// Shift-and-subtract divider giving floor(num * 2^15 / den) for num <= den.
// Depends on tbes_pkg; one quotient bit per cycle, ENV_BITS quotient bits per division.
`timescale 1ns / 1ps

module tbes_div (
  input  logic                         clk,
  input  logic                         rst,
  input  tbes_pkg::div_req_t           req,
  output logic                         done,
  output logic [tbes_pkg::ENV_BITS-1:0] quo
);
  import tbes_pkg::*;

  localparam int STEP_BITS = $clog2(ENV_BITS);
  localparam int REM_BITS  = LEN_BITS + 1;

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic [REM_BITS-1:0]  rem;
  logic [LEN_BITS-1:0]  den;
  logic [REM_BITS-1:0]  shifted;
  logic [REM_BITS-1:0]  diff;
  logic                 ge;

  // First step compares the numerator itself, later steps shift first
  always_comb begin
    shifted = (step == '0) ? rem : {rem[REM_BITS-2:0], 1'b0};
    diff    = shifted - REM_BITS'(den);
    ge      = shifted >= REM_BITS'(den);
  end

  // Control: run for ENV_BITS steps, pulse done once
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(ENV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then restore or keep the partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= REM_BITS'(req.num);
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff : shifted;
      quo <= {quo[ENV_BITS-2:0], ge};
    end
  end

endmodule

### design/tbes_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on tbes_pkg; used for the gain scale and both sample channels in turn.
`timescale 1ns / 1ps

module tbes_mul #(
  parameter int A_BITS = 17
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic signed [A_BITS-1:0]                  a,
  input  logic [tbes_pkg::GAIN_BITS-1:0]            b,
  output logic signed [A_BITS+tbes_pkg::GAIN_BITS:0] prod
);
  import tbes_pkg::*;

  // Hold the product until the next enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * $signed({1'b0, b});
    end
  end

endmodule

### design/tbes_seq.sv
// Burst, pause and repeat sequencer state with its next-state logic.
// Depends on tbes_pkg; the top level strobes update once per request.
`timescale 1ns / 1ps

module tbes_seq #(
  parameter int COUNT_BITS = tbes_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             update,
  input  logic [tbes_pkg::ACTION_BITS-1:0] action,
  input  tbes_pkg::cfg_regs_t              cfg,
  output tbes_pkg::seq_flags_t             flags,
  output tbes_pkg::seq_flags_t             flags_next,
  output logic [COUNT_BITS-1:0]            count,
  output logic                             retune_next
);
  import tbes_pkg::*;

  localparam int CMP_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

  logic [REPEAT_BITS-1:0] repeats;
  logic [COUNT_BITS-1:0]  count_next;
  logic [REPEAT_BITS-1:0] repeats_next;
  logic [COUNT_BITS-1:0]  count_inc;
  logic [REPEAT_BITS-1:0] repeats_inc;

  // Work out the state after this request
  always_comb begin
    count_inc    = count + 1'b1;
    repeats_inc  = repeats + 1'b1;
    flags_next   = flags;
    count_next   = count;
    repeats_next = repeats;
    retune_next  = 1'b0;
    unique case (action)
      ACT_START: begin
        flags_next   = '{seq_active: 1'b1, in_burst: 1'b1, second_tone: 1'b0};
        count_next   = '0;
        repeats_next = '0;
        retune_next  = 1'b1;
      end
      ACT_STOP: begin
        flags_next.seq_active = 1'b0;
      end
      ACT_TICK: begin
        if (flags.seq_active) begin
          count_next = count_inc;
          if (flags.in_burst) begin
            // End of burst: second tone or pause
            if (CMP_BITS'(count_inc) >= CMP_BITS'(cfg.burst_length)) begin
              count_next = '0;
              if (cfg.two_tone_enable && !flags.second_tone) begin
                flags_next.second_tone = 1'b1;
                retune_next            = 1'b1;
              end else begin
                flags_next.in_burst = 1'b0;
              end
            end
          end else if (CMP_BITS'(count_inc) >= CMP_BITS'(cfg.pause_length)) begin
            // End of pause: next repetition or finish
            count_next   = '0;
            repeats_next = repeats_inc;
            if (repeats_inc < cfg.repeat_count) begin
              flags_next.in_burst = 1'b1;
              if (flags.second_tone) begin
                flags_next.second_tone = 1'b0;
                retune_next            = 1'b1;
              end
            end else begin
              flags_next.seq_active = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Commit the new state
  always_ff @(posedge clk) begin
    if (rst) begin
      flags   <= '0;
      count   <= '0;
      repeats <= '0;
    end else if (update) begin
      flags   <= flags_next;
      count   <= count_next;
      repeats <= repeats_next;
    end
  end

endmodule
